// ----- rtl/core/sorted_region_table_allocator_top_defines.svh -----
// Assertion macros for the sorted region table allocator.
// Used by sorted_region_table_allocator_top; expects clk_i and rst_ni in scope.
`ifndef SORTED_REGION_TABLE_ALLOCATOR_TOP_DEFINES_SVH
`define SORTED_REGION_TABLE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srta assertion failed");

// Next-cycle implication, disabled during reset
`define SRTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srta assertion failed");

`endif

// ----- rtl/core/srta_pkg.sv -----
// Shared types, constants and address helpers for the region table allocator.
// No dependencies; imported by every module of the block.
package srta_pkg;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned PAGE_BITS   = 12;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned ENTRY_CNT_W = 7;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_BITS) - 64'd1);

  // Request codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_MAP     = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_NOGAP = 2'd2;
  localparam logic [1:0] STATUS_SPLIT = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] region_addr;
    logic [ADDR_W-1:0] region_size;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      result_addr;
    logic [1:0]             status;
    logic                   overlap_seen;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } rsp_t;

  // One table entry as held by a cell
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              fixed;
  } entry_t;

  // Shift command for one stack of cells
  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

  function automatic logic [ADDR_W-1:0] page_up(input logic [ADDR_W-1:0] a);
    return (a + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  function automatic logic [ADDR_W-1:0] page_down(input logic [ADDR_W-1:0] a);
    return a & ~PAGE_MASK;
  endfunction

  // Overlap test with strict bounds on both ends
  function automatic logic strict_overlap(input logic [ADDR_W-1:0] ab,
                                          input logic [ADDR_W-1:0] ae,
                                          input logic [ADDR_W-1:0] bb,
                                          input logic [ADDR_W-1:0] be);
    return (ab > bb && ab < be) || (ae > bb && ae < be) ||
           (bb > ab && bb < ae) || (be > ab && be < ae);
  endfunction

endpackage

// ----- rtl/core/sorted_region_table_allocator_top.sv -----
// Sorted region table allocator: two cell stacks plus the request sequencer.
// Depends on srta_pkg, srta_stack, srta_engine and the defines header.
//
// Usage:
//   Request channel: drive req_i and raise start_i; the item is taken at a
//   rising edge with start_i high and busy_o low. busy_o stays high until the
//   cycle the result is out. One request is worked on at a time.
//   Result channel: done_o is high for one cycle with rsp_o valid; the
//   receiver must take it then, it cannot stall the block.
//   Configuration: cfg_we_i with cfg_wdata_i writes the lowest address for
//   automatic allocation; write only while the block is idle.
//   From the accepting edge to done_o, a release and a fixed mapping each
//   take a forward walk and a restore walk; an automatic allocation takes a
//   search walk, restore walk, insert walk and restore walk (only the search
//   and restore walks when no gap is found or the table is full). Each walk
//   moves one entry per cycle between the two stacks of chained cells and
//   then turns around; an unused request code answers without raising busy_o.
//   Reset empties the table and sets the lowest allocation address to
//   0x10000; the cells themselves are not cleared.
`include "sorted_region_table_allocator_top_defines.svh"

module sorted_region_table_allocator_top import srta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_t              req_i,
  output logic              busy_o,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  output logic              done_o,
  output rsp_t              rsp_o
);

  stack_cmd_t right_cmd, left_cmd;
  entry_t     right_top, left_top, left_push;

  // Right stack holds the table at rest, lowest entry on top
  srta_stack u_right (
    .clk_i (clk_i),
    .cmd_i (right_cmd),
    .push_i(left_top),
    .top_o (right_top)
  );

  // Left stack collects walked entries, highest entry on top
  srta_stack u_left (
    .clk_i (clk_i),
    .cmd_i (left_cmd),
    .push_i(left_push),
    .top_o (left_top)
  );

  srta_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .right_top_i(right_top),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .right_cmd_o(right_cmd),
    .left_cmd_o (left_cmd),
    .left_push_o(left_push)
  );

  // An accepted item keeps the block busy or answers at once
  `SRTA_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o || done_o)
  // A result only comes out once the block is idle again
  `SRTA_ASSERT_IMP(a_done_idle, done_o, !busy_o)
  // Any error reports a zero address
  `SRTA_ASSERT_IMP(a_err_zero_addr, done_o && rsp_o.status != STATUS_OK, rsp_o.result_addr == '0)
  // The table never holds more than its capacity
  `SRTA_ASSERT_IMP(a_count_bound, done_o, rsp_o.entry_count <= ENTRY_CNT_W'(ENTRIES))

endmodule

// ----- rtl/core/srta_cell.sv -----
// One storage cell of an entry stack: takes its lower or upper neighbor.
// Depends on srta_pkg.
module srta_cell import srta_pkg::*; (
  input  logic       clk_i,
  input  stack_cmd_t cmd_i,
  input  entry_t     lower_i,
  input  entry_t     upper_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // Shift up on push, down on pop, hold otherwise
  always_comb begin
    if (cmd_i.push) begin
      entry_d = lower_i;
    end else if (cmd_i.pop) begin
      entry_d = upper_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/core/srta_stack.sv -----
// Stack of ENTRIES chained cells; the top sits in cell 0.
// Depends on srta_pkg and srta_cell.
module srta_stack import srta_pkg::*; (
  input  logic       clk_i,
  input  stack_cmd_t cmd_i,
  input  entry_t     push_i,
  output entry_t     top_o
);

  entry_t cell_q [ENTRIES];

  // Chain the cells: each takes its neighbor on a shift
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t lower, upper;
    if (g == 0) begin : g_first
      assign lower = push_i;
    end else begin : g_mid
      assign lower = cell_q[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign upper = cell_q[g];
    end else begin : g_inner
      assign upper = cell_q[g+1];
    end
    srta_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_i),
      .lower_i(lower),
      .upper_i(upper),
      .entry_o(cell_q[g])
    );
  end

  assign top_o = cell_q[0];

endmodule

// ----- rtl/core/srta_engine.sv -----
// Request sequencer: walks entries from the right stack to the left one and back,
// searching, inserting, trimming and dropping on the way. Depends on srta_pkg.
module srta_engine import srta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_t              req_i,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  entry_t            right_top_i,
  output logic              busy_o,
  output logic              done_o,
  output rsp_t              rsp_o,
  output stack_cmd_t        right_cmd_o,
  output stack_cmd_t        left_cmd_o,
  output entry_t            left_push_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_FWD, ST_BWD} state_e;
  typedef enum logic [1:0] {MODE_SEARCH, MODE_INSERT, MODE_RELEASE} mode_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [1:0]        op_q, op_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] rsize_q, rsize_d;
  logic [ADDR_W-1:0] dend_q, dend_d;
  logic [ADDR_W-1:0] lower_q, lower_d;
  logic [ADDR_W-1:0] found_q, found_d;
  logic [ADDR_W-1:0] lowest_q, lowest_d;
  logic              found_ok_q, found_ok_d;
  logic              ovl_q, ovl_d;
  logic              split_q, split_d;
  logic              ins_en_q, ins_en_d;
  logic              ins_done_q, ins_done_d;
  logic [CNT_W-1:0]  r_cnt_q, r_cnt_d;
  logic [CNT_W-1:0]  l_cnt_q, l_cnt_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  entry_t            head;
  logic [ADDR_W-1:0] head_end;
  logic [ADDR_W-1:0] top_pg;
  logic [ADDR_W-1:0] gap;
  logic              gap_ok;
  logic              ins_hit;

  assign head     = right_top_i;
  assign head_end = head.base + head.len;
  assign top_pg   = page_down(head.base);
  assign gap      = top_pg - lower_q;
  assign gap_ok   = (lower_q < top_pg) && (rsize_q < gap);
  assign ins_hit  = (mode_q == MODE_INSERT) && ins_en_q && !ins_done_q &&
                    ((r_cnt_q == '0) || (head.base > addr_q));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    op_d        = op_q;
    addr_d      = addr_q;
    size_d      = size_q;
    rsize_d     = rsize_q;
    dend_d      = dend_q;
    lower_d     = lower_q;
    found_d     = found_q;
    lowest_d    = lowest_q;
    found_ok_d  = found_ok_q;
    ovl_d       = ovl_q;
    split_d     = split_q;
    ins_en_d    = ins_en_q;
    ins_done_d  = ins_done_q;
    r_cnt_d     = r_cnt_q;
    l_cnt_d     = l_cnt_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    right_cmd_o = '0;
    left_cmd_o  = '0;
    left_push_o = head;

    if (cfg_we_i) begin
      lowest_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d       = req_i.op;
          addr_d     = req_i.region_addr;
          size_d     = req_i.region_size;
          rsize_d    = page_up(req_i.region_size);
          dend_d     = req_i.region_addr + req_i.region_size;
          lower_d    = lowest_q;
          found_ok_d = 1'b0;
          ovl_d      = 1'b0;
          split_d    = 1'b0;
          ins_done_d = 1'b0;
          ins_en_d   = 1'b0;
          case (req_i.op)
            OP_ALLOC: begin
              mode_d  = MODE_SEARCH;
              state_d = ST_FWD;
            end
            OP_MAP: begin
              mode_d   = MODE_INSERT;
              ins_en_d = (r_cnt_q < CNT_W'(ENTRIES));
              state_d  = ST_FWD;
            end
            OP_RELEASE: begin
              mode_d  = MODE_RELEASE;
              state_d = ST_FWD;
            end
            default: begin
              // Unused code: answer at once, table untouched
              done_d            = 1'b1;
              rsp_d             = '0;
              rsp_d.entry_count = ENTRY_CNT_W'(r_cnt_q);
            end
          endcase
        end
      end

      ST_FWD: begin
        if (ins_hit) begin
          // Place the new region below the current head
          left_cmd_o.push   = 1'b1;
          left_push_o.base  = addr_q;
          left_push_o.len   = size_q;
          left_push_o.fixed = (op_q == OP_MAP);
          l_cnt_d           = l_cnt_q + CNT_W'(1);
          ins_done_d        = 1'b1;
        end else if (r_cnt_q != '0) begin
          right_cmd_o.pop = 1'b1;
          r_cnt_d         = r_cnt_q - CNT_W'(1);
          case (mode_q)
            MODE_SEARCH: begin
              // Keep the last fitting gap: it is the highest one
              left_cmd_o.push = 1'b1;
              l_cnt_d         = l_cnt_q + CNT_W'(1);
              lower_d         = page_up(head_end);
              if (gap_ok) begin
                found_ok_d = 1'b1;
                found_d    = top_pg - rsize_q;
              end
            end
            MODE_INSERT: begin
              left_cmd_o.push = 1'b1;
              l_cnt_d         = l_cnt_q + CNT_W'(1);
              if ((op_q == OP_MAP) &&
                  strict_overlap(head.base, head_end, addr_q, dend_q)) begin
                ovl_d = 1'b1;
              end
            end
            MODE_RELEASE: begin
              if (!(head.base >= addr_q && head_end <= dend_q)) begin
                // Keep the entry: trimmed where the range cuts an end, else whole
                left_cmd_o.push = 1'b1;
                l_cnt_d         = l_cnt_q + CNT_W'(1);
                if (strict_overlap(addr_q, dend_q, head.base, head_end)) begin
                  if (head.base >= addr_q && head.base <= dend_q) begin
                    left_push_o.base = dend_q;
                    left_push_o.len  = head_end - dend_q;
                  end else if (head_end >= addr_q && head_end <= dend_q) begin
                    left_push_o.len = addr_q - head.base;
                  end else begin
                    split_d = 1'b1;
                  end
                end
              end
            end
            default: begin
              left_cmd_o.push = 1'b1;
              l_cnt_d         = l_cnt_q + CNT_W'(1);
            end
          endcase
        end else begin
          state_d = ST_BWD;
        end
      end

      ST_BWD: begin
        if (l_cnt_q != '0) begin
          // Move the table back into the right stack
          left_cmd_o.pop   = 1'b1;
          right_cmd_o.push = 1'b1;
          l_cnt_d          = l_cnt_q - CNT_W'(1);
          r_cnt_d          = r_cnt_q + CNT_W'(1);
        end else if (mode_q == MODE_SEARCH && found_ok_q &&
                     r_cnt_q != CNT_W'(ENTRIES)) begin
          // Gap found and room left: an insert walk places the region
          mode_d     = MODE_INSERT;
          addr_d     = found_q;
          ins_en_d   = 1'b1;
          ins_done_d = 1'b0;
          state_d    = ST_FWD;
        end else begin
          done_d            = 1'b1;
          state_d           = ST_IDLE;
          rsp_d             = '0;
          rsp_d.entry_count = ENTRY_CNT_W'(r_cnt_q);
          case (mode_q)
            MODE_SEARCH: begin
              rsp_d.status = found_ok_q ? STATUS_FULL : STATUS_NOGAP;
            end
            MODE_INSERT: begin
              rsp_d.overlap_seen = ovl_q;
              rsp_d.result_addr  = ins_en_q ? addr_q : '0;
              rsp_d.status       = ins_en_q ? STATUS_OK : STATUS_FULL;
            end
            MODE_RELEASE: begin
              rsp_d.status = split_q ? STATUS_SPLIT : STATUS_OK;
            end
            default: begin
              rsp_d.status = STATUS_OK;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, counters, request fields and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_SEARCH;
      op_q       <= '0;
      addr_q     <= '0;
      size_q     <= '0;
      rsize_q    <= '0;
      dend_q     <= '0;
      lower_q    <= '0;
      found_q    <= '0;
      lowest_q   <= ADDR_W'(32'h0001_0000);
      found_ok_q <= 1'b0;
      ovl_q      <= 1'b0;
      split_q    <= 1'b0;
      ins_en_q   <= 1'b0;
      ins_done_q <= 1'b0;
      r_cnt_q    <= '0;
      l_cnt_q    <= '0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      op_q       <= op_d;
      addr_q     <= addr_d;
      size_q     <= size_d;
      rsize_q    <= rsize_d;
      dend_q     <= dend_d;
      lower_q    <= lower_d;
      found_q    <= found_d;
      lowest_q   <= lowest_d;
      found_ok_q <= found_ok_d;
      ovl_q      <= ovl_d;
      split_q    <= split_d;
      ins_en_q   <= ins_en_d;
      ins_done_q <= ins_done_d;
      r_cnt_q    <= r_cnt_d;
      l_cnt_q    <= l_cnt_d;
      done_q     <= done_d;
      rsp_q      <= rsp_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
